FILE: rtl/core/i2a_pkg.sv
package i2a_pkg;

  // Value width, fixed by the reciprocal constant used for divide by ten
  localparam int VALUE_WIDTH = 32;
  // Longest text: eleven octal digits, or sign plus ten decimal digits
  localparam int TEXT_MAX = 11;
  localparam int DIG_IDX_W = $clog2(TEXT_MAX);
  localparam int COUNT_W = 4;
  localparam int CHAR_W = 8;
  localparam int OPCODE_W = 3;

  // Stream payload widths
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 16;

  // Divide by ten: q = (v * DIV10_MUL) >> DIV10_SHIFT, exact for 32-bit v
  localparam logic [VALUE_WIDTH-1:0] DIV10_MUL = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_HEXL = 3'd3,
    OP_HEXU = 3'd4
  } opcode_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted request
    logic step;   // produce one digit, least significant first
    logic emit;   // put the next character into the output register
  } i2a_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_valid;   // opcode of the offered request has a meaning
    logic quot_zero;  // this step leaves nothing more to convert
    logic slot_free;  // output register can take a character
    logic emit_last;  // the next character is the final one
  } i2a_stat_t;

  // Digit to ASCII, hex letters in the chosen case
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/core/i2a_ctrl.sv
module i2a_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  i2a_pkg::i2a_stat_t stat,
  output i2a_pkg::i2a_cmd_t  cmd
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // meaningless opcodes are taken and dropped
          if (stat.op_valid) state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.quot_zero) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/i2a_datapath.sv
module i2a_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  i2a_pkg::i2a_cmd_t                cmd,
  output i2a_pkg::i2a_stat_t               stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [i2a_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import i2a_pkg::*;

  logic [OPCODE_W-1:0]    in_op;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;

  logic [OPCODE_W-1:0]    op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic                   sign_pend_r;
  logic [DIG_IDX_W-1:0]   wp_r;
  logic [DIG_IDX_W-1:0]   rd_r;
  logic [COUNT_W-1:0]     count_r;
  logic [3:0]             dig_r [TEXT_MAX];

  logic [CHAR_W-1:0]      out_char_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_last_r;
  logic                   out_valid_r;

  logic [2*VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0]   q10;
  logic [3:0]               r10;
  logic [3:0]               q10x10_lo;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [3:0]               digit;
  logic [COUNT_W-1:0]       count_nxt;
  logic [CHAR_W-1:0]        char_nxt;

  // Unpack the request and take the magnitude of a negative signed value
  assign in_op  = in_tdata[OPCODE_W-1:0];
  assign in_val = in_tdata[OPCODE_W +: VALUE_WIDTH];
  assign in_neg = (in_op == OP_SDEC) && in_val[VALUE_WIDTH-1];

  // Divide by ten through the reciprocal; remainder needs only four bits
  assign prod      = {{VALUE_WIDTH{1'b0}}, val_r} * {{VALUE_WIDTH{1'b0}}, DIV10_MUL};
  assign q10       = VALUE_WIDTH'(prod >> DIV10_SHIFT);
  assign q10x10_lo = {q10[0], 3'b000} + {q10[2:0], 1'b0};
  assign r10       = val_r[3:0] - q10x10_lo;

  // Digit and quotient for the chosen radix
  always_comb begin
    case (op_r) inside
      OP_OCT: begin
        digit = {1'b0, val_r[2:0]};
        quot  = val_r >> 3;
      end
      OP_HEXL, OP_HEXU: begin
        digit = val_r[3:0];
        quot  = val_r >> 4;
      end
      default: begin
        digit = r10;
        quot  = q10;
      end
    endcase
  end

  // Next character: sign first, then digits from the top of the buffer
  assign count_nxt = count_r + COUNT_W'(1);
  assign char_nxt  = sign_pend_r ? CHAR_MINUS
                                 : digit_char(dig_r[rd_r], op_r == OP_HEXU);

  always_comb begin
    stat.op_valid  = (in_op <= OP_HEXU);
    stat.quot_zero = (quot == '0);
    stat.slot_free = !out_valid_r || out_tready;
    stat.emit_last = !sign_pend_r && (rd_r == '0);
  end

  // Conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      val_r   <= in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
      wp_r    <= '0;
      count_r <= '0;
    end
    if (cmd.step) begin
      dig_r[wp_r] <= digit;
      wp_r        <= wp_r + DIG_IDX_W'(1);
      val_r       <= quot;
      rd_r        <= wp_r;
    end
    if (cmd.emit) begin
      count_r <= count_nxt;
      if (!sign_pend_r) rd_r <= rd_r - DIG_IDX_W'(1);
    end
  end

  // Sign flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_pend_r <= 1'b0;
    end else if (cmd.load) begin
      sign_pend_r <= in_neg;
    end else if (cmd.emit) begin
      sign_pend_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r  <= char_nxt;
      out_count_r <= count_nxt;
      out_last_r  <= stat.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W-COUNT_W){1'b0}}, out_count_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter. Each request carries a 32-bit value and an opcode
// (signed decimal, unsigned decimal, octal, lower or upper hex); the block
// returns the text one character per output transfer, most significant digit
// first, with a leading '-' for a negative signed value, no leading zeros and
// a single '0' for zero. Each character comes with a running count and tlast
// on the final one. A request is accepted, then converted one digit per step
// (digits are found least significant first and buffered; decimal digits come
// from a reciprocal multiplier), then emitted one character at a time, each
// character waiting while the output register is full and not being taken.
// A new request is taken once the last character has entered the output
// register. Requests with an opcode above 4 are accepted and produce nothing.
module integer_to_ascii_formatter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] opcode, [34:3] value, [39:35] zero
  input  logic [i2a_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] character, [11:8] char_count, [15:12] zero
  output logic [i2a_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import i2a_pkg::*;

  i2a_cmd_t  cmd;
  i2a_stat_t stat;

  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2a_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/i2a_checker.sv
module i2a_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [i2a_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [i2a_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);
  import i2a_pkg::*;

  // An offered request holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("stalled request changed");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // A new request is only taken when any pending character ends its text
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("request taken while text still pending");

  // The sign never ends a text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[CHAR_W-1:0] != CHAR_MINUS)
    else $error("text ends in a sign");

  // Count stays in range, and eleven characters close the text
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CHAR_W +: COUNT_W] != 4'd0 &&
                   (out_tdata[CHAR_W +: COUNT_W] < 4'd11 || out_tlast) &&
                   out_tdata[CHAR_W +: COUNT_W] <= 4'd11)
    else $error("character count out of range");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
